/* sv/lcdf_pkg.sv */
// Package for the LCD serial command framer: request and result word types,
// op codes, frame phase codes and protocol byte constants. No dependencies.
`default_nettype none

package lcdf_pkg;

  // Request word fields.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_value;
    logic [7:0] second_byte;
    logic [5:0] row_pos;
    logic [3:0] column_pos;
  } req_t;

  // Result word fields.
  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last;
  } res_t;

  // Request op codes.
  localparam logic [1:0] OP_CMD     = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_TEXTPOS = 2'd2;
  localparam logic [1:0] OP_GFXWORD = 2'd3;

  // Byte position within one three-byte controller write.
  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Protocol constants.
  localparam logic [7:0] SYNC_BYTE    = 8'hF8;
  localparam logic [7:0] RS_DATA_BIT  = 8'h02;
  localparam logic [7:0] NIBBLE_MASK  = 8'hF0;
  localparam logic [7:0] CMD_EXTENDED = 8'h34;
  localparam logic [7:0] CMD_BASIC    = 8'h30;
  localparam logic [7:0] ADDR_ROW0    = 8'h80;
  localparam logic [7:0] ADDR_ROW1    = 8'h90;
  localparam logic [7:0] ADDR_GRAPHIC = 8'h80;

  // Width of the write index within a run (at most six writes).
  localparam int WIDX_W = 3;

  // Control from the sequencer to the byte generator.
  typedef struct packed {
    logic              active;
    logic [WIDX_W-1:0] widx;
    logic [1:0]        phase;
  } seq_ctl_t;

  // Status from the byte generator back to the sequencer.
  typedef struct packed {
    logic final_byte;
  } gen_sts_t;

endpackage

`default_nettype wire

/* sv/lcd_serial_command_framer_top.sv */
// Top level of the LCD serial command framer: sequencer, byte generator and
// result register. Depends on lcdf_pkg, lcdf_sequencer and lcdf_byte_gen.
// The first byte of a run passes through the sequencer's request and control
// registers and then the result register before it reaches the result ports.
// Throughput: one byte per cycle; a run is 3, 6 or 18 bytes by op, set by the
// byte generator, and the next word is taken on the final byte of a run.
// Reset clears the sequencer control and the strobe; the receiver cannot stall.
`default_nettype none

module lcd_serial_command_framer_top import lcdf_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       start,
  input  wire req_t req,
  output logic      busy,
  output logic      strobe,
  output res_t      result
);

  req_t     req_q;
  seq_ctl_t ctl;
  gen_sts_t sts;
  res_t     res_next;

  lcdf_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req_in (req),
    .sts    (sts),
    .busy   (busy),
    .req    (req_q),
    .ctl    (ctl)
  );

  lcdf_byte_gen u_gen (
    .req (req_q),
    .ctl (ctl),
    .res (res_next),
    .sts (sts)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.active;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

`default_nettype wire

/* sv/lcdf_byte_gen.sv */
// Byte generator: picks the controller write for the current write index and
// frames the current byte of it. Depends on lcdf_pkg.
`default_nettype none

module lcdf_byte_gen import lcdf_pkg::*; (
  input  wire req_t     req,
  input  wire seq_ctl_t ctl,
  output res_t          res,
  output gen_sts_t      sts
);

  logic             is_data;
  logic [7:0]       value;
  logic [WIDX_W-1:0] nwrites_m1;

  // Select the value and write kind for this write index.
  always_comb begin
    is_data    = 1'b0;
    value      = 8'h00;
    nwrites_m1 = '0;
    unique case (req.op)
      OP_CMD: begin
        value = req.byte_value;
      end
      OP_DATA: begin
        is_data = 1'b1;
        value   = req.byte_value;
      end
      OP_TEXTPOS: begin
        nwrites_m1 = WIDX_W'(1);
        if (ctl.widx == '0) begin
          value = CMD_BASIC;
        end else begin
          value = ((req.row_pos == 6'd0) ? ADDR_ROW0 : ADDR_ROW1) + {4'h0, req.column_pos};
        end
      end
      OP_GFXWORD: begin
        nwrites_m1 = WIDX_W'(5);
        case (ctl.widx)
          WIDX_W'(0): value = CMD_EXTENDED;
          WIDX_W'(1): value = ADDR_GRAPHIC + {2'b00, req.row_pos};
          WIDX_W'(2): value = ADDR_GRAPHIC + {4'h0, req.column_pos};
          WIDX_W'(3): value = CMD_BASIC;
          WIDX_W'(4): begin
            is_data = 1'b1;
            value   = req.byte_value;
          end
          default: begin
            is_data = 1'b1;
            value   = req.second_byte;
          end
        endcase
      end
      default: begin
        value = req.byte_value;
      end
    endcase
  end

  // Frame the byte for the current phase of the write.
  always_comb begin
    unique case (ctl.phase)
      PH_SYNC: res.spi_byte = SYNC_BYTE | (is_data ? RS_DATA_BIT : 8'h00);
      PH_HIGH: res.spi_byte = value & NIBBLE_MASK;
      default: res.spi_byte = {value[3:0], 4'h0};
    endcase
  end

  // The final byte is the low nibble of the last write.
  assign sts.final_byte = (ctl.phase == PH_LOW) && (ctl.widx == nwrites_m1);
  assign res.last       = sts.final_byte;

endmodule

`default_nettype wire

/* sv/lcdf_sequencer.sv */
// Sequencer: holds the accepted request and steps through its bytes, one per
// cycle, loading the next request on the final byte. Depends on lcdf_pkg.
`default_nettype none

module lcdf_sequencer import lcdf_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  wire req_t     req_in,
  input  wire gen_sts_t sts,
  output logic          busy,
  output req_t          req,
  output seq_ctl_t      ctl
);

  logic              active;
  logic [WIDX_W-1:0] widx;
  logic [1:0]        phase;
  logic              take;

  // Free on the last byte of a run, so the next word follows without a gap.
  assign busy = active && !sts.final_byte;
  assign take = start && !busy;

  assign ctl.active = active;
  assign ctl.widx   = widx;
  assign ctl.phase  = phase;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      widx   <= '0;
      phase  <= PH_SYNC;
    end else if (take) begin
      active <= 1'b1;
      widx   <= '0;
      phase  <= PH_SYNC;
    end else if (active) begin
      if (sts.final_byte) begin
        active <= 1'b0;
      end else if (phase == PH_LOW) begin
        phase <= PH_SYNC;
        widx  <= widx + WIDX_W'(1);
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (take) begin
      req <= req_in;
    end
  end

endmodule

`default_nettype wire

/* sv/lcdf_checker.sv */
// Port-level checker for the LCD serial command framer, with its bind to the
// top level. Depends on lcdf_pkg and lcd_serial_command_framer_top.
`default_nettype none

module lcdf_checker import lcdf_pkg::*; (
  input wire       clk,
  input wire       rst,
  input wire       start,
  input wire       busy,
  input wire       strobe,
  input wire res_t result
);

  // An accepted word produces its first byte on strobe once the sequencer and result registers have taken it in turn.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 strobe)
    else $error("accepted word did not produce a byte on time");

  // A run has no gaps until its final byte.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a byte run");

  // While busy, a byte is always under way.
  assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("busy without a byte following");

  // A byte right after a final byte opens a new write with a sync byte.
  assert property (@(posedge clk) disable iff (rst)
    strobe && result.last ##1 strobe |-> result.spi_byte[7:2] == 6'b111110)
    else $error("run does not open with a sync byte");

endmodule

bind lcd_serial_command_framer_top lcdf_checker u_lcdf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

`default_nettype wire

/* tb/sv/tb_lcd_serial_command_framer_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LCD serial command framer: predicts the serial
// byte run of every accepted request word and checks each strobed byte in order.
// Depends on lcdf_pkg and lcd_serial_command_framer_top.

module tb_lcd_serial_command_framer_top;
  import lcdf_pkg::*;

  // Predicted serial bytes, checked against the strobed result words in order.
  class frame_board;
    res_t serial_bytes[$];
    int   mismatches = 0;

    task report(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      mismatches++;
    endtask

    // One controller write: sync byte, high nibble, then low nibble moved up.
    function void push_write(input bit is_data, input logic [7:0] value,
                             input bit closes_run);
      res_t b;
      b.spi_byte = SYNC_BYTE | (is_data ? RS_DATA_BIT : 8'h00);
      b.last = 1'b0;
      serial_bytes.push_back(b);
      b.spi_byte = value & NIBBLE_MASK;
      serial_bytes.push_back(b);
      b.spi_byte = {value[3:0], 4'h0};
      b.last = closes_run;
      serial_bytes.push_back(b);
    endfunction

    // Expand one accepted request word into its run of serial bytes.
    function void note_word(input req_t w);
      logic [7:0] text_addr;
      text_addr = ((w.row_pos == 6'd0) ? ADDR_ROW0 : ADDR_ROW1) + {4'h0, w.column_pos};
      case (w.op)
        OP_CMD: begin
          push_write(1'b0, w.byte_value, 1'b1);
        end
        OP_DATA: begin
          push_write(1'b1, w.byte_value, 1'b1);
        end
        OP_TEXTPOS: begin
          push_write(1'b0, CMD_BASIC, 1'b0);
          push_write(1'b0, text_addr, 1'b1);
        end
        default: begin
          push_write(1'b0, CMD_EXTENDED, 1'b0);
          push_write(1'b0, ADDR_GRAPHIC + {2'b00, w.row_pos}, 1'b0);
          push_write(1'b0, ADDR_GRAPHIC + {4'h0, w.column_pos}, 1'b0);
          push_write(1'b0, CMD_BASIC, 1'b0);
          push_write(1'b1, w.byte_value, 1'b0);
          push_write(1'b1, w.second_byte, 1'b1);
        end
      endcase
    endfunction

    // Compare one strobed byte with the oldest prediction.
    task check_byte(input res_t got);
      res_t want;
      if (serial_bytes.size() == 0) begin
        report($sformatf("unexpected byte %h last %b", got.spi_byte, got.last));
        return;
      end
      want = serial_bytes.pop_front();
      if (got.spi_byte !== want.spi_byte)
        report($sformatf("spi_byte %h, expected %h", got.spi_byte, want.spi_byte));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b (byte %h)", got.last, want.last,
                         want.spi_byte));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic strobe;
  res_t result;

  frame_board board = new();
  int burst_left;

  lcd_serial_command_framer_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both sides at each rising edge: note accepted words, check strobed bytes.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        board.note_word(req);
      if (strobe)
        board.check_byte(result);
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(input req_t w);
    start <= 1'b1;
    req   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Send a word, then idle between bursts; some bursts are long with no gaps.
  task automatic put_word(input req_t w);
    int gap;
    send_word(w);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 24);
      start <= 1'b0;
      req   <= req_t'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  function automatic req_t make_word(input logic [1:0] op, input logic [7:0] b0,
                                     input logic [7:0] b1, input logic [5:0] row,
                                     input logic [3:0] col);
    req_t w;
    w.op          = op;
    w.byte_value  = b0;
    w.second_byte = b1;
    w.row_pos     = row;
    w.column_pos  = col;
    return w;
  endfunction

  function automatic req_t random_word();
    req_t w;
    w = req_t'({$urandom, $urandom});
    // Bias text rows toward zero so both address bases come up often.
    if ($urandom_range(0, 3) == 0)
      w.row_pos = 6'd0;
    return w;
  endfunction

  // Stimulus: directed corners first, then random words.
  initial begin
    start <= 1'b0;
    req   <= '0;
    rst   <= 1'b1;
    burst_left = 5;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Command and data bytes at the extremes; unused fields all ones, all zeros or mixed.
    put_word(make_word(OP_CMD, 8'h00, 8'hFF, 6'h3F, 4'hF));
    put_word(make_word(OP_CMD, 8'hFF, 8'h00, 6'h00, 4'h0));
    put_word(make_word(OP_CMD, 8'hA5, 8'h5A, 6'h2A, 4'h5));
    // Graphic display enable is sent as an ordinary command.
    put_word(make_word(OP_CMD, 8'h36, 8'h00, 6'h00, 4'h0));
    put_word(make_word(OP_DATA, 8'h00, 8'hFF, 6'h3F, 4'hF));
    put_word(make_word(OP_DATA, 8'hFF, 8'h00, 6'h00, 4'h0));
    put_word(make_word(OP_DATA, 8'h5A, 8'hA5, 6'h15, 4'hA));
    // Text position: row zero and non-zero rows, column extremes.
    put_word(make_word(OP_TEXTPOS, 8'hFF, 8'hFF, 6'h00, 4'h0));
    put_word(make_word(OP_TEXTPOS, 8'h00, 8'h00, 6'h00, 4'hF));
    put_word(make_word(OP_TEXTPOS, 8'h12, 8'h34, 6'h01, 4'h7));
    put_word(make_word(OP_TEXTPOS, 8'h00, 8'hFF, 6'h3F, 4'hF));
    put_word(make_word(OP_TEXTPOS, 8'hFF, 8'h00, 6'h20, 4'h0));
    // Graphic word: row and column extremes, pixel bytes at both ends.
    put_word(make_word(OP_GFXWORD, 8'h00, 8'hFF, 6'h00, 4'h0));
    put_word(make_word(OP_GFXWORD, 8'hFF, 8'h00, 6'h3F, 4'hF));
    put_word(make_word(OP_GFXWORD, 8'hA5, 8'h5A, 6'h1F, 4'h8));
    put_word(make_word(OP_GFXWORD, 8'h81, 8'h18, 6'h20, 4'h1));

    repeat (380) put_word(random_word());

    start <= 1'b0;
    while (board.serial_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
sv/lcdf_pkg.sv
sv/lcdf_byte_gen.sv
sv/lcdf_sequencer.sv
sv/lcd_serial_command_framer_top.sv
sv/lcdf_checker.sv
tb/sv/tb_lcd_serial_command_framer_top.sv
